@@ sv/lbr_pkg.sv @@
// Shared constants and types for the 48-bit LCG bounded random generator.
// No dependencies; used by lbr_lcg, lbr_mod and lcg48_bounded_random_top.
package lbr_pkg;

    localparam int STATE_W  = 48;
    localparam int MULT_W   = 35;
    localparam int CHUNK_W  = 16;
    localparam int CHUNKS   = STATE_W / CHUNK_W;
    localparam int CNT_W    = $clog2(CHUNKS);
    localparam int PROD_W   = CHUNK_W + MULT_W;
    localparam int BITS_W   = 31;
    localparam int WORD_W   = 32;
    localparam int DIV_CNT_W = $clog2(BITS_W);

    localparam logic [MULT_W-1:0]  LCG_MULT    = 35'h5DEECE66D;
    localparam logic [STATE_W-1:0] LCG_MULT_48 = 48'h0005DEECE66D;
    localparam logic [STATE_W-1:0] LCG_ADD     = 48'h00000000000B;
    localparam logic [BITS_W-1:0]  BOUND_RESET = 31'd10000;

    localparam logic [1:0] OP_RESEED  = 2'd0;
    localparam logic [1:0] OP_FULL    = 2'd1;
    localparam logic [1:0] OP_BOUNDED = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

@@ sv/lbr_lcg.sv @@
// LCG advance unit: state * 0x5DEECE66D + 0xB mod 2^48, one 16-bit chunk per cycle.
// Depends on lbr_pkg.
module lbr_lcg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lbr_pkg::STATE_W-1:0] seed,
    output logic [lbr_pkg::STATE_W-1:0] result,
    output lbr_pkg::unit_stat_t         stat
);

    logic [lbr_pkg::STATE_W-1:0] acc_reg, acc_next;
    logic [lbr_pkg::STATE_W-1:0] src_reg, src_next;
    logic [lbr_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [lbr_pkg::PROD_W-1:0]  prod;
    logic                        last;

    always_comb
    begin
        last     = (cnt_reg == lbr_pkg::CNT_W'(lbr_pkg::CHUNKS - 1));
        prod     = src_reg[lbr_pkg::STATE_W-1 -: lbr_pkg::CHUNK_W] * lbr_pkg::LCG_MULT;
        acc_next  = acc_reg;
        src_next  = src_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            src_next  = seed;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // Horner step: shift accumulator up one chunk, add next partial product
            acc_next = {acc_reg[lbr_pkg::STATE_W-lbr_pkg::CHUNK_W-1:0],
                        {lbr_pkg::CHUNK_W{1'b0}}}
                       + prod[lbr_pkg::STATE_W-1:0]
                       + (last ? lbr_pkg::LCG_ADD : '0);
            src_next = {src_reg[lbr_pkg::STATE_W-lbr_pkg::CHUNK_W-1:0],
                        {lbr_pkg::CHUNK_W{1'b0}}};
            cnt_next = cnt_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        src_reg <= src_next;
    end

    assign result    = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

@@ sv/lbr_mod.sv @@
// Serial remainder unit: 31-bit dividend mod 31-bit divisor, one restoring step per cycle.
// Depends on lbr_pkg.
module lbr_mod (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [lbr_pkg::BITS_W-1:0] dividend,
    input  logic [lbr_pkg::BITS_W-1:0] divisor,
    output logic [lbr_pkg::BITS_W-1:0] remainder,
    output lbr_pkg::unit_stat_t        stat
);

    logic [lbr_pkg::BITS_W-1:0]    rem_reg, rem_next;
    logic [lbr_pkg::BITS_W-1:0]    dvd_reg, dvd_next;
    logic [lbr_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [lbr_pkg::WORD_W-1:0]    trial;
    logic [lbr_pkg::WORD_W-1:0]    dsr_ext;
    logic [lbr_pkg::WORD_W-1:0]    diff;
    logic                          ge;

    always_comb
    begin
        trial   = {rem_reg, dvd_reg[lbr_pkg::BITS_W-1]};
        dsr_ext = {1'b0, divisor};
        diff    = trial - dsr_ext;
        ge      = (trial >= dsr_ext);
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            dvd_next  = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[lbr_pkg::BITS_W-1:0] : trial[lbr_pkg::BITS_W-1:0];
            dvd_next = {dvd_reg[lbr_pkg::BITS_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == lbr_pkg::DIV_CNT_W'(lbr_pkg::BITS_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
    end

    assign remainder = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

@@ sv/lcg48_bounded_random_top.sv @@
// A reseed beat gives no result. A full draw passes through the chunked LCG multiplier,
// then sequencing and the output register. A bounded draw with a power-of-two bound takes
// the same path. Any other bound adds the serial remainder unit, one bit per cycle over
// the 31 dividend bits; each rare rejection repeats the multiply and the remainder. A
// bounded draw with bound 0 returns 0 without advancing the state. Input is not taken
// while a draw is in progress, but a new beat is taken while a finished result waits in
// the output register.
//
// Top level of the 48-bit LCG bounded random generator.
// Depends on lbr_pkg, lbr_lcg and lbr_mod.
module lcg48_bounded_random_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        opcode,
    input  logic [lbr_pkg::STATE_W-1:0]       seed_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [lbr_pkg::WORD_W-1:0] value,
    input  logic                              cfg_wr_en,
    input  logic [lbr_pkg::BITS_W-1:0]        cfg_wr_data
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_ADV  = 5'b00010,
        ST_POST = 5'b00100,
        ST_MOD  = 5'b01000,
        ST_FIN  = 5'b10000
    } state_t;

    state_t                        state_reg, state_next;
    logic [lbr_pkg::STATE_W-1:0]   lcg_reg, lcg_next;
    logic [lbr_pkg::BITS_W-1:0]    bound_reg;
    logic [1:0]                    op_reg, op_next;
    logic [lbr_pkg::WORD_W-1:0]    res_reg, res_next;
    logic                          out_valid_reg, out_valid_next;
    logic [lbr_pkg::WORD_W-1:0]    value_reg, value_next;

    logic                          lcg_start;
    logic [lbr_pkg::STATE_W-1:0]   lcg_result;
    lbr_pkg::unit_stat_t           lcg_stat;
    logic                          mod_start;
    logic [lbr_pkg::BITS_W-1:0]    mod_rem;
    lbr_pkg::unit_stat_t           mod_stat;

    logic                          accept;
    logic                          out_load;
    logic [lbr_pkg::BITS_W-1:0]    draw_bits;
    logic                          pow2;
    logic [2*lbr_pkg::BITS_W-1:0]  scaled;
    logic [lbr_pkg::WORD_W-1:0]    chk;

    lbr_lcg u_lcg (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (lcg_start),
        .seed   (lcg_reg),
        .result (lcg_result),
        .stat   (lcg_stat)
    );

    lbr_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (draw_bits),
        .divisor   (bound_reg),
        .remainder (mod_rem),
        .stat      (mod_stat)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        draw_bits = lcg_reg[lbr_pkg::STATE_W-1 -: lbr_pkg::BITS_W];
        pow2      = ((bound_reg & (bound_reg - 1'b1)) == '0);
        scaled    = {{lbr_pkg::BITS_W{1'b0}}, bound_reg} *
                    {{lbr_pkg::BITS_W{1'b0}}, draw_bits};
        chk       = {1'b0, draw_bits} - {1'b0, mod_rem} + {1'b0, bound_reg - 1'b1};
        out_load  = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);

        state_next = state_reg;
        lcg_next   = lcg_reg;
        op_next    = op_reg;
        res_next   = res_reg;
        lcg_start  = 1'b0;
        mod_start  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next = opcode;
                    case (opcode)
                        lbr_pkg::OP_RESEED:
                        begin
                            lcg_next = seed_value ^ lbr_pkg::LCG_MULT_48;
                        end
                        lbr_pkg::OP_FULL:
                        begin
                            lcg_start  = 1'b1;
                            state_next = ST_ADV;
                        end
                        lbr_pkg::OP_BOUNDED:
                        begin
                            if (bound_reg == '0)
                            begin
                                res_next   = '0;
                                state_next = ST_FIN;
                            end
                            else
                            begin
                                lcg_start  = 1'b1;
                                state_next = ST_ADV;
                            end
                        end
                        default:
                        begin
                            // drop unused opcode
                        end
                    endcase
                end
            end
            ST_ADV:
            begin
                if (lcg_stat.done)
                begin
                    lcg_next   = lcg_result;
                    state_next = ST_POST;
                end
            end
            ST_POST:
            begin
                if (op_reg == lbr_pkg::OP_FULL)
                begin
                    res_next   = lcg_reg[lbr_pkg::STATE_W-1 -: lbr_pkg::WORD_W];
                    state_next = ST_FIN;
                end
                else if (pow2)
                begin
                    res_next   = {1'b0, scaled[2*lbr_pkg::BITS_W-1 -: lbr_pkg::BITS_W]};
                    state_next = ST_FIN;
                end
                else
                begin
                    mod_start  = 1'b1;
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (mod_stat.done)
                begin
                    if (chk[lbr_pkg::WORD_W-1])
                    begin
                        // redraw on biased remainder
                        lcg_start  = 1'b1;
                        state_next = ST_ADV;
                    end
                    else
                    begin
                        res_next   = {1'b0, mod_rem};
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            value_next     = res_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lcg_reg       <= lbr_pkg::LCG_MULT_48;
            bound_reg     <= lbr_pkg::BOUND_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lcg_reg       <= lcg_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                bound_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        res_reg   <= res_next;
        value_reg <= value_next;
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;

    a_lcg_done_in_adv: assert property (@(posedge clk) disable iff (!rst_n)
        lcg_stat.done |-> (state_reg == ST_ADV))
        else $error("LCG unit finished outside advance state");

    a_mod_done_in_mod: assert property (@(posedge clk) disable iff (!rst_n)
        mod_stat.done |-> (state_reg == ST_MOD))
        else $error("remainder unit finished outside modulo state");

    a_units_idle_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (!lcg_stat.busy && !mod_stat.busy))
        else $error("input beat taken while an arithmetic unit is busy");

    a_bounded_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (op_reg == lbr_pkg::OP_BOUNDED) && (bound_reg != '0))
        |=> ($unsigned(value) < {1'b0, bound_reg}))
        else $error("bounded draw outside bound");

endmodule
